FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CHK_HOLDS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fatce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT32 cluster chain engine package
// Shared widths, codes, packing positions and types.
// ----------------------------------------------------------------------------
package fatce_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES      = 4096;
    localparam int ENTRIES_PER_SECTOR = 128;
    localparam int TBL_AW             = $clog2(TABLE_ENTRIES);
    localparam int TBL_CW             = TBL_AW + 1;
    localparam int EPS_SH             = $clog2(ENTRIES_PER_SECTOR);

    // Field widths
    localparam int CLU_W  = 12;
    localparam int WORD_W = 32;
    localparam int SPC_W  = 8;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int CIDX_W = 2;

    // Stream packing
    localparam int IN_CLU_LSB   = 0;
    localparam int IN_VAL_LSB   = IN_CLU_LSB + CLU_W;
    localparam int IN_TDATA_W   = ((IN_VAL_LSB + WORD_W + 7) / 8) * 8;
    localparam int OUT_SEC_LSB  = 0;
    localparam int OUT_CLU_LSB  = OUT_SEC_LSB + WORD_W;
    localparam int OUT_FSEC_LSB = OUT_CLU_LSB + CLU_W;
    localparam int OUT_PAD_LSB  = OUT_FSEC_LSB + WORD_W;
    localparam int OUT_TDATA_W  = ((OUT_PAD_LSB + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_PAD_LSB;

    // Command queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Constants
    localparam logic [WORD_W-1:0] FULL_ENTRY     = '1;
    localparam logic [WORD_W-1:0] END_MARKER_RST = 32'h0FFF_FFF8;
    localparam logic [SPC_W-1:0]  SPC_RST        = 8'd1;
    localparam logic [WORD_W-1:0] CLU_BIAS       = 32'd2;
    localparam logic [WORD_W-1:0] CLU_MAX        = WORD_W'((1 << CLU_W) - 1);
    localparam logic [WORD_W-1:0] TBL_LIMIT      = WORD_W'(TABLE_ENTRIES);

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD  = 2'd0,
        FN_START = 2'd1,
        FN_NEXT  = 2'd2,
        FN_ALLOC = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_END   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_DATA_START = 2'd0,
        CFG_FAT_START  = 2'd1,
        CFG_SPC        = 2'd2,
        CFG_END_MARKER = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_ADD,
        BK_FOLLOW,
        BK_SCAN,
        BK_DONE
    } bk_state_t;

    // Configuration as seen by the execution side
    typedef struct packed {
        logic [WORD_W-1:0] data_start;
        logic [WORD_W-1:0] fat_start;
        logic [SPC_W-1:0]  spc_eff;
        logic [WORD_W-1:0] end_marker;
    } cfg_t;

    // One queued command
    typedef struct packed {
        func_t              func;
        logic [CLU_W-1:0]   cluster;
        logic [WORD_W-1:0]  value;
    } item_t;

    // One result
    typedef struct packed {
        logic [WORD_W-1:0] sector;
        logic [CLU_W-1:0]  cluster_out;
        logic [WORD_W-1:0] fat_sector;
        status_t           status;
    } res_t;

endpackage

FILE: src/fat32_cluster_chain_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT32 cluster chain engine
// Keeps an allocation table, walks cluster chains and allocates free clusters.
// ----------------------------------------------------------------------------
//  Channel   Signals                         Carries
//  s_*       tvalid tready tdata tuser       command item in
//  m_*       tvalid tready tdata tuser       result item out
//  cfg_*     we index wdata                  register writes
//
// Load and start items go from idle straight to the done state, as does a next
// item on an ended chain; a next item that returns a sector passes the multiply
// and add registers (after a table read in the follow state across a cluster
// boundary), and one whose followed entry ends the chain goes from follow to done.
// Allocate items read one entry per cycle until a free entry or the table end.
// Reset is asynchronous and active low and leaves the table uncleared; a two-entry
// queue keeps accepting items while a result waits on m_tready.
// ----------------------------------------------------------------------------
module fat32_cluster_chain_engine
    import fatce_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CIDX_W-1:0]      cfg_index,
    input  logic [WORD_W-1:0]      cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [11:0] cluster, [43:12] entry_value, [47:44] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] func
    input  logic [FUNC_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] sector, [43:32] cluster_out, [75:44] fat_sector, [79:76] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [STAT_W-1:0]      m_tuser
);

    cfg_t  cfg;
    item_t push_item;
    item_t head;
    logic  push;
    logic  q_full;
    logic  q_empty;
    logic  pop;

    fatce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item),
        .cfg       (cfg)
    );

    fatce_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    fatce_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: src/fatce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT32 chain engine front end
// Holds the configuration registers and unpacks incoming items for the queue.
// ----------------------------------------------------------------------------
module fatce_front
    import fatce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [WORD_W-1:0]     cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [FUNC_W-1:0]     s_tuser,
    input  logic                  q_full,
    output logic                  push,
    output item_t                 push_item,
    output cfg_t                  cfg
);

    logic [WORD_W-1:0] data_start_reg;
    logic [WORD_W-1:0] fat_start_reg;
    logic [SPC_W-1:0]  spc_reg;
    logic [WORD_W-1:0] end_marker_reg;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg <= '0;
            fat_start_reg  <= '0;
            spc_reg        <= SPC_RST;
            end_marker_reg <= END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DATA_START: data_start_reg <= cfg_wdata;
                CFG_FAT_START:  fat_start_reg  <= cfg_wdata;
                CFG_SPC:        spc_reg        <= cfg_wdata[SPC_W-1:0];
                CFG_END_MARKER: end_marker_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // A zero cluster size behaves as one sector per cluster.
    always_comb
    begin
        cfg.data_start = data_start_reg;
        cfg.fat_start  = fat_start_reg;
        cfg.spc_eff    = (spc_reg == '0) ? SPC_RST : spc_reg;
        cfg.end_marker = end_marker_reg;
    end

    // Accept whenever the queue has room and decode the item kind.
    assign s_tready          = !q_full;
    assign push              = s_tvalid && !q_full;
    assign push_item.func    = func_t'(s_tuser);
    assign push_item.cluster = s_tdata[IN_CLU_LSB +: CLU_W];
    assign push_item.value   = s_tdata[IN_VAL_LSB +: WORD_W];

endmodule

FILE: src/fatce_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT32 chain engine command queue
// Small FIFO between the front end and the execution side.
// ----------------------------------------------------------------------------
module fatce_queue
    import fatce_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head,
    output logic  empty
);

    item_t           slot_mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == (Q_AW + 1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_mem[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/fatce_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT32 chain engine execution side
// Owns the allocation table, walks chains, scans for free entries and holds
// the output register.
// ----------------------------------------------------------------------------
module fatce_back
    import fatce_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  item_t                  head,
    input  logic                   q_empty,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [STAT_W-1:0]      m_tuser
);

    // Allocation table
    logic [WORD_W-1:0] table_mem [TABLE_ENTRIES];
    logic              mem_we;
    logic              mem_re;
    logic [TBL_AW-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] rdata_reg;

    bk_state_t         state_reg, state_next;
    logic [CLU_W-1:0]  chain_clu_reg, chain_clu_next;
    logic [SPC_W-1:0]  offset_reg, offset_next;
    logic              ended_reg, ended_next;
    logic [CLU_W-1:0]  sec_clu_reg, sec_clu_next;
    logic [SPC_W-1:0]  sec_off_reg, sec_off_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [TBL_CW-1:0] issue_reg, issue_next;
    logic [TBL_AW-1:0] chk_reg, chk_next;
    logic              pend_reg, pend_next;
    res_t              res_reg, res_next;
    logic              out_valid_reg;
    res_t              out_res_reg;
    logic              load_out;

    logic [WORD_W+SPC_W-1:0] mul_full;
    logic                    scan_hit;
    logic                    nxt_in_range;

    // Sector offset of a cluster: (cluster - 2) * sectors per cluster.
    assign mul_full     = (WORD_W'(sec_clu_reg) - CLU_BIAS) * cfg.spc_eff;
    assign scan_hit     = pend_reg && (rdata_reg == '0);
    assign nxt_in_range = (rdata_reg < TBL_LIMIT) && (rdata_reg <= CLU_MAX);

    // Table port: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= table_mem[mem_addr];
        end
    end

    // Sequencer state and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            chain_clu_reg <= '0;
            offset_reg    <= '0;
            ended_reg     <= 1'b1;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_clu_reg <= chain_clu_next;
            offset_reg    <= offset_next;
            ended_reg     <= ended_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sec_clu_reg <= sec_clu_next;
        sec_off_reg <= sec_off_next;
        prod_reg    <= prod_next;
        issue_reg   <= issue_next;
        chk_reg     <= chk_next;
        res_reg     <= res_next;
    end

    // Next state and table control.
    always_comb
    begin
        state_next     = state_reg;
        chain_clu_next = chain_clu_reg;
        offset_next    = offset_reg;
        ended_next     = ended_reg;
        sec_clu_next   = sec_clu_reg;
        sec_off_next   = sec_off_reg;
        prod_next      = prod_reg;
        issue_next     = issue_reg;
        chk_next       = chk_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = TBL_AW'(chain_clu_reg);
        mem_wdata      = head.value;
        load_out       = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    res_next = '{sector: '0, cluster_out: head.cluster,
                                 fat_sector: '0, status: ST_OK};
                    unique case (head.func)
                        FN_LOAD:
                        begin
                            mem_addr = TBL_AW'(head.cluster);
                            if (WORD_W'(head.cluster) < TBL_LIMIT)
                            begin
                                mem_we = 1'b1;
                            end
                            else
                            begin
                                res_next.status = ST_RANGE;
                            end
                            state_next = BK_DONE;
                        end
                        FN_START:
                        begin
                            chain_clu_next = head.cluster;
                            offset_next    = '0;
                            ended_next     = 1'b0;
                            state_next     = BK_DONE;
                        end
                        FN_NEXT:
                        begin
                            res_next.cluster_out = chain_clu_reg;
                            if (ended_reg)
                            begin
                                res_next.status = ST_END;
                                state_next      = BK_DONE;
                            end
                            else if (offset_reg < cfg.spc_eff)
                            begin
                                // Still inside the current cluster.
                                sec_clu_next = chain_clu_reg;
                                sec_off_next = offset_reg;
                                offset_next  = offset_reg + 1'b1;
                                state_next   = BK_MUL;
                            end
                            else if (WORD_W'(chain_clu_reg) >= TBL_LIMIT)
                            begin
                                ended_next      = 1'b1;
                                res_next.status = ST_RANGE;
                                state_next      = BK_DONE;
                            end
                            else
                            begin
                                // Cluster exhausted: fetch its table entry.
                                mem_re     = 1'b1;
                                state_next = BK_FOLLOW;
                            end
                        end
                        FN_ALLOC:
                        begin
                            issue_next = '0;
                            pend_next  = 1'b0;
                            state_next = BK_SCAN;
                        end
                        default: ;
                    endcase
                end
            end

            BK_MUL:
            begin
                prod_next  = mul_full[WORD_W-1:0];
                state_next = BK_ADD;
            end

            BK_ADD:
            begin
                res_next.sector      = cfg.data_start + prod_reg + WORD_W'(sec_off_reg);
                res_next.cluster_out = chain_clu_reg;
                res_next.status      = ST_OK;
                state_next           = BK_DONE;
            end

            BK_FOLLOW:
            begin
                // Follow the table entry, or end the chain.
                if (rdata_reg >= cfg.end_marker)
                begin
                    ended_next      = 1'b1;
                    res_next.status = ST_END;
                    state_next      = BK_DONE;
                end
                else if (!nxt_in_range)
                begin
                    ended_next      = 1'b1;
                    res_next.status = ST_RANGE;
                    state_next      = BK_DONE;
                end
                else
                begin
                    chain_clu_next = CLU_W'(rdata_reg);
                    sec_clu_next   = CLU_W'(rdata_reg);
                    sec_off_next   = '0;
                    offset_next    = SPC_W'(1);
                    state_next     = BK_MUL;
                end
            end

            BK_SCAN:
            begin
                // Pipelined search: read one entry while checking the last.
                if (scan_hit)
                begin
                    mem_we     = 1'b1;
                    mem_addr   = chk_reg;
                    mem_wdata  = FULL_ENTRY;
                    pend_next  = 1'b0;
                    res_next   = '{sector: '0, cluster_out: CLU_W'(chk_reg),
                                   fat_sector: cfg.fat_start + WORD_W'(chk_reg >> EPS_SH),
                                   status: ST_OK};
                    state_next = BK_DONE;
                end
                else if (issue_reg < TBL_CW'(TABLE_ENTRIES))
                begin
                    mem_re     = 1'b1;
                    mem_addr   = issue_reg[TBL_AW-1:0];
                    pend_next  = 1'b1;
                    chk_next   = issue_reg[TBL_AW-1:0];
                    issue_next = issue_reg + 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    res_next   = '{sector: '0, cluster_out: '0,
                                   fat_sector: '0, status: ST_FULL};
                    state_next = BK_DONE;
                end
            end

            BK_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_res_reg <= res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_res_reg.fat_sector,
                       out_res_reg.cluster_out, out_res_reg.sector};
    assign m_tuser  = out_res_reg.status;

endmodule

FILE: src/fatce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT32 chain engine port checker
// Watches the result port for handshake and result-format rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fatce_checker
    import fatce_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]      m_tuser
);

    // A stalled result stays offered and unchanged.
    `CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Only a successful chain step carries a sector number.
    `CHK_HOLDS(a_sector_zero, (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[OUT_CLU_LSB-1:OUT_SEC_LSB] == '0), "sector set on a failed item")

    // A full disk reports no cluster and no table sector.
    `CHK_HOLDS(a_full_zero, (m_tvalid && (m_tuser == ST_FULL)) |-> (m_tdata[OUT_PAD_LSB-1:OUT_CLU_LSB] == '0), "disk full with a cluster")

    // Padding above the packed fields is always zero.
    `CHK_HOLDS(a_pad_zero, m_tvalid |-> (m_tdata[OUT_TDATA_W-1:OUT_PAD_LSB] == '0), "result padding not zero")

endmodule

bind fat32_cluster_chain_engine fatce_checker u_fatce_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster chain engine testbench
// Walks chains, loads the whole allocation table, runs directed chain walks, allocations
// and register settings, followed by random phases of chain walks, table
// updates and allocations. Every accepted command item is predicted on the
// spot and each result item is checked field by field against the oldest
// prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    import fatce_pkg::*;

    localparam int IDLE_PCT    = 28;
    localparam int STALL_LIMIT = 20000;
    localparam int LOW_FREE    = 64;
    localparam int PHASE_ITEMS = 88;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CIDX_W-1:0]      cfg_index;
    logic [WORD_W-1:0]      cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    // [11:0] cluster, [43:12] entry_value, [47:44] zero
    logic [IN_TDATA_W-1:0]  s_tdata;
    // [1:0] func
    logic [FUNC_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [31:0] sector, [43:32] cluster_out, [75:44] fat_sector, [79:76] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    // [1:0] status
    logic [STAT_W-1:0]      m_tuser;

    // Shadow copy of the engine state and its registers.
    logic [WORD_W-1:0] shadow_fat [TABLE_ENTRIES];
    logic [CLU_W-1:0]  walk_cluster;
    logic [SPC_W-1:0]  walk_offset;
    logic              walk_done;
    logic [WORD_W-1:0] reg_data_start;
    logic [WORD_W-1:0] reg_fat_start;
    logic [SPC_W-1:0]  reg_spc;
    logic [WORD_W-1:0] reg_end_marker;

    res_t pending_results [$];
    int   error_count = 0;
    int   quiet_cycles = 0;
    bit   src_idle_en = 1'b1;
    bit   sink_idle_en = 1'b1;

    fat32_cluster_chain_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // A zero sectors-per-cluster setting behaves as one.
    function automatic logic [WORD_W-1:0] spc_eff();
        return (reg_spc == '0) ? WORD_W'(1) : WORD_W'(reg_spc);
    endfunction

    // Absolute sector of a cluster and offset; wraps modulo 2^32.
    function automatic logic [WORD_W-1:0] cluster_sector(logic [CLU_W-1:0] clu,
                                                         logic [SPC_W-1:0] off);
        logic [WORD_W-1:0] rel;
        rel = WORD_W'(clu) - WORD_W'(2);
        return rel * spc_eff() + reg_data_start + WORD_W'(off);
    endfunction

    // Computes the result of one command item and updates the shadow state.
    function automatic res_t chain_engine_step(func_t fn, logic [CLU_W-1:0] clu,
                                               logic [WORD_W-1:0] val);
        res_t              r;
        logic [WORD_W-1:0] nxt;
        r        = '0;
        r.status = ST_OK;
        case (fn)
            FN_LOAD:
            begin
                // A 12-bit index always fits the table.
                r.cluster_out   = clu;
                shadow_fat[clu] = val;
            end
            FN_START:
            begin
                walk_cluster  = clu;
                walk_offset   = '0;
                walk_done     = 1'b0;
                r.cluster_out = clu;
            end
            FN_NEXT:
            begin
                if (walk_done)
                    r.status = ST_END;
                else if (WORD_W'(walk_offset) < spc_eff())
                begin
                    r.sector    = cluster_sector(walk_cluster, walk_offset);
                    walk_offset = walk_offset + 1'b1;
                end
                else
                begin
                    // The current cluster is 12 bits wide, so it is always a valid index.
                    nxt = shadow_fat[walk_cluster];
                    if (nxt >= reg_end_marker)
                    begin
                        walk_done = 1'b1;
                        r.status  = ST_END;
                    end
                    else if (nxt >= TBL_LIMIT)
                    begin
                        walk_done = 1'b1;
                        r.status  = ST_RANGE;
                    end
                    else
                    begin
                        walk_cluster = nxt[CLU_W-1:0];
                        r.sector     = cluster_sector(walk_cluster, '0);
                        walk_offset  = SPC_W'(1);
                    end
                end
                r.cluster_out = walk_cluster;
            end
            default:
            begin
                // Allocation takes the lowest free entry.
                r.status = ST_FULL;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (r.status == ST_FULL && shadow_fat[i] == '0)
                    begin
                        shadow_fat[i] = '1;
                        r.cluster_out = CLU_W'(i);
                        r.fat_sector  = reg_fat_start + WORD_W'(i / ENTRIES_PER_SECTOR);
                        r.status      = ST_OK;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Table entry mix: mostly links, some end markers, some links beyond the table.
    function automatic logic [WORD_W-1:0] rand_link();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return WORD_W'($urandom_range(TABLE_ENTRIES - 1, LOW_FREE));
        else if (pick < 60)
            return WORD_W'($urandom_range(LOW_FREE - 1, 0));
        else if (pick < 75)
            return WORD_W'($urandom_range(32'hFFFF_FFFF, 32'h0FFF_FFF8));
        else if (pick < 87)
            return WORD_W'($urandom_range(32'h0FFF_FFF7, TABLE_ENTRIES));
        else
            return WORD_W'($urandom());
    endfunction

    function automatic logic [CLU_W-1:0] rand_cluster();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            return CLU_W'($urandom_range(TABLE_ENTRIES - 1, LOW_FREE));
        else if (pick < 90)
            return CLU_W'($urandom_range(LOW_FREE - 1, 0));
        else if (pick < 94)
            return CLU_W'(0);
        else if (pick < 97)
            return CLU_W'(1);
        else
            return CLU_W'(TABLE_ENTRIES - 1);
    endfunction

    // Offers one command item and records its prediction once accepted.
    task automatic send_item(func_t fn, logic [CLU_W-1:0] clu, logic [WORD_W-1:0] val);
        while (src_idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= IN_TDATA_W'({val, clu});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(chain_engine_step(fn, clu, val));
    endtask

    // Holds the sender until every predicted result item has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [WORD_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_DATA_START: reg_data_start = val;
            CFG_FAT_START:  reg_fat_start  = val;
            CFG_SPC:        reg_spc        = val[SPC_W-1:0];
            default:        reg_end_marker = val;
        endcase
    endtask

    // Rewrites all registers while the engine is idle.
    task automatic set_config(logic [WORD_W-1:0] ds, logic [WORD_W-1:0] fs,
                              logic [SPC_W-1:0] spc, logic [WORD_W-1:0] em);
        drain_results();
        write_reg(CFG_DATA_START, ds);
        write_reg(CFG_FAT_START, fs);
        write_reg(CFG_SPC, WORD_W'(spc));
        write_reg(CFG_END_MARKER, em);
        cfg_we <= 1'b0;
    endtask

    // Next items before the table is loaded: no chain, then first sectors only.
    task automatic test_walk_before_load();
        send_item(FN_NEXT, '1, '1);
        send_item(FN_START, CLU_W'(5), '0);
        send_item(FN_NEXT, '0, '0);
        send_item(FN_START, CLU_W'(0), '0);
        send_item(FN_NEXT, '0, '0);
        send_item(FN_START, CLU_W'(TABLE_ENTRIES - 1), '0);
        send_item(FN_NEXT, '0, '0);
    endtask

    // Every entry is written once; the lowest entries are left free.
    task automatic test_table_load();
        for (int i = 0; i < TABLE_ENTRIES; i++)
            send_item(FN_LOAD, CLU_W'(i), (i < LOW_FREE) ? WORD_W'(0) : rand_link());
    endtask

    // Chain endings under the reset register values.
    task automatic test_chain_endings();
        send_item(FN_LOAD, CLU_W'(100), WORD_W'(101));
        send_item(FN_LOAD, CLU_W'(101), WORD_W'(102));
        send_item(FN_LOAD, CLU_W'(102), END_MARKER_RST);
        send_item(FN_LOAD, CLU_W'(103), END_MARKER_RST - 1);
        send_item(FN_LOAD, CLU_W'(104), WORD_W'(TABLE_ENTRIES - 1));
        send_item(FN_LOAD, CLU_W'(TABLE_ENTRIES - 1), '1);
        send_item(FN_LOAD, CLU_W'(105), WORD_W'(1));
        // Two links, then an entry exactly at the end marker.
        send_item(FN_START, CLU_W'(100), '0);
        repeat (5) send_item(FN_NEXT, '0, '0);
        // An entry just below the end marker lies beyond the table.
        send_item(FN_START, CLU_W'(103), '0);
        repeat (2) send_item(FN_NEXT, '0, '0);
        // Last table index, then an all-ones entry.
        send_item(FN_START, CLU_W'(104), '0);
        repeat (3) send_item(FN_NEXT, '0, '0);
        // Clusters one and zero wrap the sector arithmetic.
        send_item(FN_START, CLU_W'(105), '0);
        repeat (3) send_item(FN_NEXT, '0, '0);
    endtask

    // Allocation at both ends of the table, wrapped table sector and disk full.
    task automatic test_alloc_and_full();
        send_item(FN_ALLOC, '0, '0);
        send_item(FN_ALLOC, '1, '1);
        set_config('0, 32'hFFFF_FFF0, SPC_RST, END_MARKER_RST);
        send_item(FN_LOAD, CLU_W'(TABLE_ENTRIES - 1), '0);
        for (int i = 0; i < TABLE_ENTRIES - 1; i++)
        begin
            if (shadow_fat[i] == '0)
                send_item(FN_LOAD, CLU_W'(i), WORD_W'($urandom()) | WORD_W'(1));
        end
        send_item(FN_ALLOC, '0, '0);
        send_item(FN_ALLOC, '0, '0);
        send_item(FN_ALLOC, '0, '0);
        for (int i = 0; i < LOW_FREE; i++)
            send_item(FN_LOAD, CLU_W'(i), '0);
        send_item(FN_ALLOC, '0, '0);
    endtask

    // Register extremes: end marker zero and all ones, sector counts 0, 255 and 128.
    task automatic test_config_extremes();
        set_config('1, '1, '0, '0);
        send_item(FN_START, CLU_W'(100), '0);
        repeat (3) send_item(FN_NEXT, '0, '0);
        send_item(FN_ALLOC, '0, '0);
        set_config(32'h8000_0000, '0, 8'd255, '1);
        send_item(FN_START, CLU_W'(TABLE_ENTRIES - 1), '0);
        repeat (3) send_item(FN_NEXT, '0, '0);
        set_config(WORD_W'($urandom()), WORD_W'($urandom()), 8'd128, '1);
        send_item(FN_START, CLU_W'(2), '0);
        repeat (2) send_item(FN_NEXT, '0, '0);
    endtask

    // Mostly chain walks with random content; the rest table updates,
    // allocations and random noise items.
    task automatic run_random_items(int count);
        int sent;
        int pick;
        int walk_len;
        int walk_max;
        logic [CLU_W-1:0] idx;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                walk_max = 3 * int'(spc_eff()) + 4;
                if (walk_max > 24)
                    walk_max = 24;
                walk_len = $urandom_range(walk_max, 1);
                send_item(FN_START, rand_cluster(), WORD_W'($urandom()));
                repeat (walk_len)
                    send_item(FN_NEXT, CLU_W'($urandom()), WORD_W'($urandom()));
                sent += walk_len + 1;
            end
            else if (pick < 70)
            begin
                send_item(FN_ALLOC, CLU_W'($urandom()), WORD_W'($urandom()));
                sent++;
            end
            else if (pick < 90)
            begin
                if ($urandom_range(1) == 0)
                begin
                    idx = CLU_W'($urandom_range(2 * LOW_FREE - 1, 0));
                    send_item(FN_LOAD, idx, ($urandom_range(1) == 0) ? WORD_W'(0) : rand_link());
                end
                else
                    send_item(FN_LOAD, CLU_W'($urandom()), rand_link());
                sent++;
            end
            else
            begin
                send_item(func_t'($urandom_range(3)), CLU_W'($urandom()), WORD_W'($urandom()));
                sent++;
            end
            if ($urandom_range(49) == 0)
                drain_results();
        end
    endtask

    task automatic test_random_phases();
        logic [WORD_W-1:0] ds;
        logic [WORD_W-1:0] fs;
        logic [WORD_W-1:0] em;
        logic [SPC_W-1:0]  spc;
        for (int p = 0; p < 8; p++)
        begin
            case ($urandom_range(3))
                0:       ds = '0;
                1:       ds = '1;
                default: ds = WORD_W'($urandom());
            endcase
            case ($urandom_range(3))
                0:       fs = '0;
                1:       fs = '1;
                default: fs = WORD_W'($urandom());
            endcase
            case ($urandom_range(4))
                0:       em = '0;
                1:       em = '1;
                2:       em = WORD_W'($urandom_range(32'hFFFF_FFFF, TABLE_ENTRIES));
                default: em = END_MARKER_RST;
            endcase
            case (p)
                0:       spc = 8'd1;
                1:       spc = 8'd2;
                2:       spc = 8'd0;
                3:       spc = SPC_W'($urandom_range(4, 3));
                4:       spc = 8'd255;
                5:       spc = 8'd128;
                6:       spc = SPC_W'($urandom_range(8, 1));
                default: spc = 8'd1;
            endcase
            set_config(ds, fs, spc, em);
            // The last phase runs with neither side idling.
            src_idle_en  = (p != 7);
            sink_idle_en = (p != 7);
            run_random_items(PHASE_ITEMS);
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // Result sink with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !(sink_idle_en && $urandom_range(99) < IDLE_PCT);
    end

    // Compares each accepted result item with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item: tdata %h, tuser %h", m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[OUT_SEC_LSB +: WORD_W] !== want.sector)
                begin
                    $error("sector: expected %h, got %h", want.sector,
                           m_tdata[OUT_SEC_LSB +: WORD_W]);
                    error_count++;
                end
                if (m_tdata[OUT_CLU_LSB +: CLU_W] !== want.cluster_out)
                begin
                    $error("cluster_out: expected %h, got %h", want.cluster_out,
                           m_tdata[OUT_CLU_LSB +: CLU_W]);
                    error_count++;
                end
                if (m_tdata[OUT_FSEC_LSB +: WORD_W] !== want.fat_sector)
                begin
                    $error("fat_sector: expected %h, got %h", want.fat_sector,
                           m_tdata[OUT_FSEC_LSB +: WORD_W]);
                    error_count++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // Ends the run when no item moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_DATA_START;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = FN_LOAD;
        reg_data_start = '0;
        reg_fat_start  = '0;
        reg_spc        = SPC_RST;
        reg_end_marker = END_MARKER_RST;
        walk_cluster   = '0;
        walk_offset    = '0;
        walk_done      = 1'b1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            shadow_fat[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_walk_before_load();
        test_table_load();
        test_chain_endings();
        test_alloc_and_full();
        test_config_extremes();
        test_random_phases();

        drain_results();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
